[design/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU page replacement engine.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int FRAME_COUNT  = 16;
    localparam int PAGE_COUNT   = 64;
    localparam int PAGE_W       = $clog2(PAGE_COUNT);
    localparam int SLOT_W       = $clog2(FRAME_COUNT);
    localparam int NFR_W        = $clog2(FRAME_COUNT + 1);
    localparam int COUNT_W      = 16;
    localparam int ACTIVE_W     = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(4);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

    typedef logic [PAGE_W-1:0]   t_page;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [NFR_W-1:0]    t_nfr;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [ACTIVE_W-1:0] t_active;

    typedef struct packed {
        t_page page;
    } t_req;

    typedef struct packed {
        logic   fault;
        t_slot  frame_slot;
        logic   evicted_valid;
        t_page  evicted_page;
        t_count use_count;
        t_count fault_total;
    } t_result;

    function automatic t_count sat_inc(input t_count v);
        return (v == COUNT_MAX) ? v : t_count'(v + 1'b1);
    endfunction

endpackage

[design/lfu_page_replacement_top.sv]
// on a hit or a fill of an empty frame, an accepted reference passes through the lookup and counter update states
// eviction adds a scan over the frames in use, one counter read per frame
// the engine takes a new reference only once the last result is registered, which waits while the output is held
// a two-entry input queue keeps accepting while a result waits to be taken, until the queue is full
// reset empties all frames and clears all use counters at once through per-page valid bits
// ----------------------------------------------------------------------------
// lfu_page_replacement_top
// LFU page replacement engine: input queue in front, lookup and victim
// scan engine behind it, one result per page reference.
// ----------------------------------------------------------------------------
module lfu_page_replacement_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  lfu_pkg::t_page   i_page,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_fault,
    output lfu_pkg::t_slot   o_frame_slot,
    output logic             o_evicted_valid,
    output lfu_pkg::t_page   o_evicted_page,
    output lfu_pkg::t_count  o_use_count,
    output lfu_pkg::t_count  o_fault_total,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  lfu_pkg::t_active i_cfg_data
);
    import lfu_pkg::*;

    logic    q_valid;
    t_req    q_req;
    logic    q_pop;
    t_result result;

    lfu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_page    (i_page),
        .o_q_valid (q_valid),
        .o_q_req   (q_req),
        .i_q_pop   (q_pop)
    );

    lfu_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (result)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_fault         = result.fault;
    assign o_frame_slot    = result.frame_slot;
    assign o_evicted_valid = result.evicted_valid;
    assign o_evicted_page  = result.evicted_page;
    assign o_use_count     = result.use_count;
    assign o_fault_total   = result.fault_total;

endmodule

[design/lfu_front.sv]
// ----------------------------------------------------------------------------
// lfu_front
// Accepts page references and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module lfu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lfu_pkg::t_page i_page,
    output logic          o_q_valid,
    output lfu_pkg::t_req o_q_req,
    input  logic          i_q_pop
);
    import lfu_pkg::*;

    t_req              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_ready   = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_buf[r_rptr];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_buf[r_wptr].page <= i_page;
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(r_wptr + 1'b1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(r_rptr + 1'b1);
            end
            if (push && !pop) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (pop && !push) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

endmodule

[design/lfu_engine.sv]
// ----------------------------------------------------------------------------
// lfu_engine
// Frame lookup, victim scan over the counter store and result register.
// ----------------------------------------------------------------------------
module lfu_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  lfu_pkg::t_req    i_q_req,
    output logic             o_q_pop,
    input  logic             i_cfg_valid,
    input  lfu_pkg::t_active i_cfg_data,
    output logic             o_valid,
    input  logic             i_ready,
    output lfu_pkg::t_result o_result
);
    import lfu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_CNT
    } t_state;

    t_state    r_state;
    t_active   r_active;
    logic      r_frm_valid [FRAME_COUNT];
    t_page     r_frm_page  [FRAME_COUNT];
    t_nfr      r_filled;
    t_count    r_fault_cnt;
    t_page     r_pg;
    t_slot     r_slot;
    logic      r_fault;
    logic      r_ev_valid;
    t_page     r_ev_page;
    t_nfr      r_idx;
    logic      r_cmp_go;
    t_slot     r_cmp_idx;
    logic      r_found;
    t_count    r_best;
    logic      r_out_valid;
    t_result   r_out;

    t_count    r_cnt_mem [PAGE_COUNT];
    logic      r_cnt_vld [PAGE_COUNT];
    t_count    r_rd_data;
    logic      r_rd_vld;

    t_nfr      n_use;
    t_page     rd_addr;
    t_count    rd_value;
    t_count    new_count;
    logic      hit;
    t_slot     hit_slot;
    logic      scan_issue;
    logic      scan_done;
    logic      out_free;
    logic      commit;

    always_comb begin
        if (r_active == '0) begin
            n_use = NFR_W'(1);
        end else if (NFR_W'(r_active) > NFR_W'(FRAME_COUNT)) begin
            n_use = NFR_W'(FRAME_COUNT);
        end else begin
            n_use = NFR_W'(r_active);
        end
    end

    // lowest active frame holding the page
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
            if ((NFR_W'(i) < n_use) && r_frm_valid[i] && (r_frm_page[i] == r_pg)) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign scan_issue = (r_idx < n_use);
    assign scan_done  = !scan_issue && !r_cmp_go;
    assign rd_addr    = (r_state == S_SCAN && scan_issue) ? r_frm_page[r_idx[SLOT_W-1:0]] : r_pg;
    assign rd_value   = r_rd_vld ? r_rd_data : '0;
    assign new_count  = sat_inc(rd_value);
    assign out_free   = !r_out_valid || i_ready;
    assign commit     = (r_state == S_CNT) && out_free;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    // counter store
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_cnt_mem[rd_addr];
        if (commit) begin
            r_cnt_mem[r_pg] <= new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RESET;
            r_filled    <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
            r_cmp_go    <= 1'b0;
            r_rd_vld    <= 1'b0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_frm_valid[i] <= 1'b0;
            end
            for (int i = 0; i < PAGE_COUNT; i++) begin
                r_cnt_vld[i] <= 1'b0;
            end
        end else begin
            r_rd_vld <= r_cnt_vld[rd_addr];
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            if (r_out_valid && i_ready && !commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_pg    <= i_q_req.page;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_ev_valid <= 1'b0;
                    r_ev_page  <= '0;
                    if (hit) begin
                        r_slot  <= hit_slot;
                        r_fault <= 1'b0;
                        r_state <= S_CNT;
                    end else if (r_filled < n_use) begin
                        r_slot   <= r_filled[SLOT_W-1:0];
                        r_filled <= NFR_W'(r_filled + 1'b1);
                        r_fault  <= 1'b1;
                        r_state  <= S_CNT;
                    end else begin
                        r_idx    <= '0;
                        r_cmp_go <= 1'b0;
                        r_found  <= 1'b0;
                        r_best   <= '0;
                        r_slot   <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cmp_go && (!r_found || rd_value < r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= rd_value;
                        r_slot  <= r_cmp_idx;
                    end
                    if (scan_issue) begin
                        r_cmp_go  <= r_frm_valid[r_idx[SLOT_W-1:0]];
                        r_cmp_idx <= r_idx[SLOT_W-1:0];
                        r_idx     <= NFR_W'(r_idx + 1'b1);
                    end else begin
                        r_cmp_go <= 1'b0;
                    end
                    if (scan_done) begin
                        r_fault    <= 1'b1;
                        r_ev_valid <= r_found;
                        r_ev_page  <= r_found ? r_frm_page[r_slot] : '0;
                        r_slot     <= r_found ? r_slot : '0;
                        r_state    <= S_CNT;
                    end
                end
                S_CNT: begin
                    if (out_free) begin
                        r_cnt_vld[r_pg] <= 1'b1;
                        if (r_fault) begin
                            r_frm_valid[r_slot] <= 1'b1;
                            r_frm_page[r_slot]  <= r_pg;
                            r_fault_cnt         <= sat_inc(r_fault_cnt);
                        end
                        r_out_valid         <= 1'b1;
                        r_out.fault         <= r_fault;
                        r_out.frame_slot    <= r_slot;
                        r_out.evicted_valid <= r_ev_valid;
                        r_out.evicted_page  <= r_ev_page;
                        r_out.use_count     <= new_count;
                        r_out.fault_total   <= r_fault ? sat_inc(r_fault_cnt) : r_fault_cnt;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
